>>> rtl/core/sstsd_pkg.sv
// Shared types, constants and the digit shape table for the seven-segment scan driver.
package sstsd_pkg;

  // Number of display positions and derived widths
  localparam int DIGITS = 3;
  localparam int POS_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int WIDX_W = $clog2(DIGITS + 1);

  // Command queue depth between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Segment bits
  localparam logic [7:0] SEG_MINUS = 8'h40;
  localparam logic [7:0] SEG_POINT = 8'h80;

  // Characters of interest
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_POINT = 8'h2E;

  typedef enum logic [1:0] {
    FUNC_CHAR  = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_RAW   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    CLS_DIGIT = 2'd0,
    CLS_MINUS = 2'd1,
    CLS_POINT = 2'd2,
    CLS_OTHER = 2'd3
  } char_cls_t;

  // One decoded command as it travels through the queue
  typedef struct packed {
    func_t      func;
    logic       first;
    char_cls_t  cls;
    logic [7:0] pattern;
    logic [1:0] raw_pos;
  } op_t;

  // Seven-segment shape of a decimal digit, bit0 is segment a
  function automatic logic [7:0] digit_shape(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/core/sstsd_front.sv
// Front end: accepts input transactions and decodes them into queue commands.
module sstsd_front (
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_func,
  input  logic             in_first_char,
  input  logic [7:0]       in_char_code,
  input  logic [1:0]       in_raw_position,
  input  logic [7:0]       in_raw_pattern,
  input  logic             q_full,
  output logic             q_push,
  output sstsd_pkg::op_t   q_push_op
);
  import sstsd_pkg::*;

  char_cls_t  cls;
  logic [7:0] digit_off;

  // Take a transaction whenever the queue has room
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign digit_off = in_char_code - CHR_ZERO;

  // Character class and the pattern it writes
  always_comb begin
    priority if (in_char_code >= CHR_ZERO && in_char_code <= CHR_NINE) begin
      cls = CLS_DIGIT;
    end else if (in_char_code == CHR_MINUS) begin
      cls = CLS_MINUS;
    end else if (in_char_code == CHR_POINT) begin
      cls = CLS_POINT;
    end else begin
      cls = CLS_OTHER;
    end

    q_push_op.func    = func_t'(in_func);
    q_push_op.first   = in_first_char;
    q_push_op.cls     = cls;
    q_push_op.raw_pos = in_raw_position;
    unique case (func_t'(in_func))
      FUNC_RAW:  q_push_op.pattern = in_raw_pattern;
      FUNC_CHAR: q_push_op.pattern = (cls == CLS_DIGIT) ? digit_shape(digit_off[3:0])
                                                          : SEG_MINUS;
      default:   q_push_op.pattern = '0;
    endcase
  end

endmodule

>>> rtl/core/sstsd_queue.sv
// Short command queue between the front and back ends.
module sstsd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sstsd_pkg::op_t push_op,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output sstsd_pkg::op_t pop_op
);
  import sstsd_pkg::*;

  op_t               entries_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_op    = entries_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

>>> rtl/core/sstsd_back.sv
// Back end: segment store, text write index, scan position and result register.
module sstsd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_not_empty,
  input  sstsd_pkg::op_t q_op,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_segments,
  output logic [2:0]     out_digit_enable,
  output logic [1:0]     out_position
);
  import sstsd_pkg::*;

  logic [7:0]        store_r [DIGITS];
  logic [7:0]        store_nxt [DIGITS];
  logic [WIDX_W-1:0] widx_r, widx_nxt;
  logic [POS_W-1:0]  scan_r, scan_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_segments_r;
  logic [2:0]        out_digit_enable_r;
  logic [1:0]        out_position_r;
  logic [WIDX_W-1:0] idx;
  logic [2:0]        enable;
  logic              out_free;
  logic              do_tick;

  assign out_valid        = out_valid_r;
  assign out_segments     = out_segments_r;
  assign out_digit_enable = out_digit_enable_r;
  assign out_position     = out_position_r;

  // A tick needs the result register free (or emptying this cycle)
  assign out_free = !out_valid_r || out_ready;
  assign q_pop    = q_not_empty && ((q_op.func != FUNC_TICK) || out_free);
  assign do_tick  = q_pop && (q_op.func == FUNC_TICK);
  assign idx      = q_op.first ? '0 : widx_r;

  // One-hot enable, zero for positions beyond the output field
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      enable[k] = (32'(scan_r) == k);
    end
  end

  // Command execution
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      store_nxt[i] = store_r[i];
    end
    widx_nxt      = widx_r;
    scan_nxt      = scan_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (q_pop) begin
      unique case (q_op.func)
        FUNC_CHAR: begin
          widx_nxt = idx;
          if (idx < WIDX_W'(DIGITS)) begin
            unique case (q_op.cls)
              CLS_DIGIT, CLS_MINUS: begin
                for (int i = 0; i < DIGITS; i++) begin
                  if (idx == WIDX_W'(i)) begin
                    store_nxt[i] = q_op.pattern;
                  end
                end
                widx_nxt = idx + 1'b1;
              end
              CLS_POINT: begin
                for (int i = 0; i < DIGITS; i++) begin
                  if (idx == WIDX_W'(i + 1)) begin
                    store_nxt[i] = store_r[i] | SEG_POINT;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        FUNC_TICK: begin
          out_valid_nxt = 1'b1;
          scan_nxt = (scan_r == POS_W'(DIGITS - 1)) ? '0 : scan_r + 1'b1;
        end
        FUNC_CLEAR: begin
          for (int i = 0; i < DIGITS; i++) begin
            store_nxt[i] = '0;
          end
        end
        FUNC_RAW: begin
          for (int i = 0; i < DIGITS; i++) begin
            if (32'(q_op.raw_pos) == i) begin
              store_nxt[i] = q_op.pattern;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Control and store state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIGITS; i++) begin
        store_r[i] <= '0;
      end
      widx_r      <= '0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i < DIGITS; i++) begin
        store_r[i] <= store_nxt[i];
      end
      widx_r      <= widx_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, loaded on a tick
  always_ff @(posedge clk) begin
    if (do_tick) begin
      out_segments_r     <= store_r[scan_r];
      out_digit_enable_r <= enable;
      out_position_r     <= 2'(scan_r);
    end
  end

endmodule

>>> rtl/core/seven_segment_text_scan_driver.sv
// Top level of the seven-segment text and scan driver.
//
// Input channel (in_*): one transaction per command. in_func selects a text
// character, a scan tick, a store clear or a raw pattern write. Characters
// fill the display store left to right; in_first_char restarts at position 0.
// Output channel (out_*): one transaction per scan tick, carrying the shown
// position's segments, its one-hot digit enable and the position index.
// Other commands give no output transaction.
// Throughput: one input transaction per cycle when the output is taken.
// Path of a tick: it is written into the command queue, then popped and loaded
// into the result register, which drives out_*. The command queue has two
// entries and feeds the back end, which executes one command per cycle
// unless a tick at the head waits for the result register to be free.
// Reset (rst_n low, synchronous) blanks the store, zeroes the write index
// and scan position and empties the queue and result register.
// When the receiver stalls, the result register holds its transaction; text,
// clear and raw commands ahead of the next tick keep executing, then that
// tick waits at the head of the queue, which fills and drops in_ready.
module seven_segment_text_scan_driver (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_func,
  input  logic       in_first_char,
  input  logic [7:0] in_char_code,
  input  logic [1:0] in_raw_position,
  input  logic [7:0] in_raw_pattern,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_segments,
  output logic [2:0] out_digit_enable,
  output logic [1:0] out_position
);
  import sstsd_pkg::*;

  logic q_full;
  logic q_push;
  op_t  q_push_op;
  logic q_pop;
  logic q_not_empty;
  op_t  q_pop_op;

  sstsd_front u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_first_char   (in_first_char),
    .in_char_code    (in_char_code),
    .in_raw_position (in_raw_position),
    .in_raw_pattern  (in_raw_pattern),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_push_op       (q_push_op)
  );

  sstsd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_op   (q_push_op),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_op    (q_pop_op)
  );

  sstsd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_not_empty      (q_not_empty),
    .q_op             (q_pop_op),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_segments     (out_segments),
    .out_digit_enable (out_digit_enable),
    .out_position     (out_position)
  );

endmodule

>>> rtl/core/sstsd_checker.sv
// Port-level checker for the seven-segment scan driver, bound to the top level.
module sstsd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_segments,
  input logic [2:0] out_digit_enable,
  input logic [1:0] out_position
);

  // A stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_segments)
      && $stable(out_digit_enable) && $stable(out_position))
    else $error("result changed while stalled");

  // Enable matches the shown position
  a_enable_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_position == 2'd0 && out_digit_enable == 3'b001)
      || (out_position == 2'd1 && out_digit_enable == 3'b010)
      || (out_position == 2'd2 && out_digit_enable == 3'b100))
    else $error("digit enable does not match position");

  // Reset empties the result register
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // An accepted result at position 0 directly followed by another accepted result is at position 1
  a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && $past(out_valid && out_ready) && $past(rst_n)
      && $past(out_position) == 2'd0 |-> out_position == 2'd1)
    else $error("scan position skipped");

endmodule

bind seven_segment_text_scan_driver sstsd_checker u_sstsd_checker (.*);

>>> bench/seven_segment_text_scan_driver_test.sv
// Self-checking testbench for the seven-segment text and scan driver.
`timescale 1ns / 100ps

module seven_segment_text_scan_driver_test;
  import sstsd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1300;
  localparam int QUIET_ITEMS = 200;

  // Segment shapes of the decimal digits, bit0 is segment a
  localparam logic [7:0] SHAPES [10] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
                                         8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};

  typedef struct {
    logic [7:0] segments;
    logic [2:0] digit_enable;
    logic [1:0] position;
  } scan_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_func;
  logic       in_first_char;
  logic [7:0] in_char_code;
  logic [1:0] in_raw_position;
  logic [7:0] in_raw_pattern;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_segments;
  logic [2:0] out_digit_enable;
  logic [1:0] out_position;

  // Shadow copy of the display state
  logic [7:0] seg_store [DIGITS];
  int         text_idx;
  int         scan_pos;
  scan_t      scan_q [$];

  bit idle_on;
  bit stall_on;
  int errors;
  int items_sent;
  int scans_checked;
  int cycles;

  seven_segment_text_scan_driver u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_first_char    (in_first_char),
    .in_char_code     (in_char_code),
    .in_raw_position  (in_raw_position),
    .in_raw_pattern   (in_raw_pattern),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_segments     (out_segments),
    .out_digit_enable (out_digit_enable),
    .out_position     (out_position)
  );

  always #4 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d scan results still outstanding", $time, scan_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Update the shadow state for one command; ticks queue their expected scan
  function automatic void apply_cmd(func_t f, bit first, logic [7:0] code,
                                    logic [1:0] rpos, logic [7:0] rpat);
    scan_t s;
    case (f)
      FUNC_CHAR: begin
        if (first) text_idx = 0;
        if (text_idx < DIGITS) begin
          if (code >= CHR_ZERO && code <= CHR_NINE) begin
            seg_store[text_idx] = SHAPES[code - CHR_ZERO];
            text_idx++;
          end else if (code == CHR_MINUS) begin
            seg_store[text_idx] = SEG_MINUS;
            text_idx++;
          end else if (code == CHR_POINT && text_idx > 0) begin
            seg_store[text_idx - 1] = seg_store[text_idx - 1] | SEG_POINT;
          end
        end
      end
      FUNC_TICK: begin
        s.segments     = seg_store[scan_pos];
        s.digit_enable = 3'(1 << scan_pos);
        s.position     = 2'(scan_pos);
        scan_q.push_back(s);
        scan_pos = (scan_pos + 1 >= DIGITS) ? 0 : scan_pos + 1;
      end
      FUNC_CLEAR: begin
        for (int i = 0; i < DIGITS; i++) seg_store[i] = 8'h00;
      end
      default: begin
        if (rpos < DIGITS) seg_store[rpos] = rpat;
      end
    endcase
  endfunction

  // Send one command transaction; called and returns at a rising edge
  task automatic send_cmd(func_t f, bit first, logic [7:0] code,
                          logic [1:0] rpos, logic [7:0] rpat);
    bit taken;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_func         <= f;
    in_first_char   <= first;
    in_char_code    <= code;
    in_raw_position <= rpos;
    in_raw_pattern  <= rpat;
    apply_cmd(f, first, code, rpos, rpat);
    items_sent++;
    do begin
      @(negedge clk);
      taken = in_valid && in_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  // Text character with random filler in the unused raw fields
  task automatic send_char(bit first, logic [7:0] code);
    send_cmd(FUNC_CHAR, first, code, 2'($urandom), 8'($urandom));
  endtask

  task automatic send_tick();
    send_cmd(FUNC_TICK, 1'($urandom), 8'($urandom), 2'($urandom), 8'($urandom));
  endtask

  // A character that the text front end acts on
  function automatic logic [7:0] text_char();
    int r;
    r = $urandom_range(0, 11);
    if (r < 10) return CHR_ZERO + 8'(r);
    return (r == 10) ? CHR_MINUS : CHR_POINT;
  endfunction

  // Result side: the receiver stalls in random bursts
  initial begin
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (stall_on && out_ready && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each scan transaction with the oldest prediction
  always @(negedge clk) begin
    scan_t want;
    if (rst_n && out_valid && out_ready) begin
      if (scan_q.size() == 0) begin
        $display("%0t: unexpected scan result seg=%h en=%b pos=%0d", $time,
                 out_segments, out_digit_enable, out_position);
        errors++;
      end else begin
        want = scan_q.pop_front();
        scans_checked++;
        if (out_segments !== want.segments) begin
          $display("%0t: segments expected %h actual %h", $time, want.segments,
                   out_segments);
          errors++;
        end
        if (out_digit_enable !== want.digit_enable) begin
          $display("%0t: digit_enable expected %b actual %b", $time,
                   want.digit_enable, out_digit_enable);
          errors++;
        end
        if (out_position !== want.position) begin
          $display("%0t: position expected %0d actual %0d", $time, want.position,
                   out_position);
          errors++;
        end
      end
    end
  end

  // Blank display straight after reset, scan wraps after the last digit
  task automatic test_blank_scan();
    repeat (DIGITS + 1) send_tick();
  endtask

  // Text entry: minus, digits, points, full store, restart and ignored characters
  task automatic test_text_entry();
    send_char(1'b1, CHR_MINUS);
    send_char(1'b0, CHR_NINE);
    send_char(1'b0, CHR_POINT);
    send_char(1'b0, CHR_ZERO);
    send_char(1'b0, CHR_ZERO + 8'd5);   // store full, dropped
    send_char(1'b0, CHR_POINT);         // store full, point dropped too
    repeat (DIGITS) send_tick();
    send_char(1'b1, 8'hFF);             // ignored but restarts the text
    send_char(1'b0, CHR_POINT);         // point at the start does nothing
    send_char(1'b0, CHR_ZERO + 8'd7);   // other positions keep old contents
    send_char(1'b0, 8'h00);
    repeat (DIGITS) send_tick();
  endtask

  // Raw writes, out-of-range position and clear
  task automatic test_raw_and_clear();
    send_cmd(FUNC_RAW, 1'b1, 8'hFF, 2'd0, 8'hFF);
    send_cmd(FUNC_RAW, 1'b0, 8'h00, 2'd2, 8'h00);
    send_cmd(FUNC_RAW, 1'b1, 8'hAA, 2'd3, 8'hAA);
    repeat (DIGITS) send_tick();
    send_cmd(FUNC_CLEAR, 1'b1, 8'hFF, 2'd3, 8'hFF);
    send_tick();
  endtask

  // Mostly well-formed strings followed by ticks, with noise mixed in
  task automatic test_random_traffic(int n_items);
    int sent;
    int len;
    int ticks;
    sent = 0;
    while (sent < n_items) begin
      if (sent % 150 == 0 && n_items > QUIET_ITEMS) begin
        idle_on  = ($urandom_range(0, 3) != 0);
        stall_on = ($urandom_range(0, 3) != 0);
      end
      case ($urandom_range(0, 9))
        0, 1: begin
          send_cmd(func_t'($urandom_range(0, 3)), 1'($urandom), 8'($urandom),
                   2'($urandom), 8'($urandom));
          sent++;
        end
        2: begin
          send_cmd(FUNC_RAW, 1'($urandom), 8'($urandom), 2'($urandom), 8'($urandom));
          send_tick();
          sent += 2;
        end
        default: begin
          len = $urandom_range(1, DIGITS + 2);
          for (int i = 0; i < len; i++) send_char(i == 0, text_char());
          sent += len;
          if ($urandom_range(0, 3) == 0) begin
            send_cmd(FUNC_CLEAR, 1'($urandom), 8'($urandom),
                     2'($urandom), 8'($urandom));
            sent++;
          end
          ticks = $urandom_range(1, DIGITS + 1);
          repeat (ticks) send_tick();
          sent += ticks;
        end
      endcase
    end
  endtask

  initial begin
    errors = 0;
    items_sent = 0;
    scans_checked = 0;
    cycles = 0;
    idle_on = 1'b1;
    stall_on = 1'b1;
    for (int i = 0; i < DIGITS; i++) seg_store[i] = 8'h00;
    text_idx = 0;
    scan_pos = 0;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_func         <= FUNC_CHAR;
    in_first_char   <= 1'b0;
    in_char_code    <= 8'h00;
    in_raw_position <= 2'd0;
    in_raw_pattern  <= 8'h00;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_blank_scan();
    test_text_entry();
    test_raw_and_clear();
    test_random_traffic(RANDOM_ITEMS);
    idle_on  = 1'b0;
    stall_on = 1'b0;
    test_random_traffic(QUIET_ITEMS);

    // Drain the remaining scan transactions, then allow for the pipeline
    in_valid <= 1'b0;
    while (scan_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d commands (text, ticks, raw writes, clears) with random idling;",
             items_sent);
    $display("checked %0d scan results, %0d mismatches.", scans_checked, errors);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> seven_segment_text_scan_driver.f
rtl/core/sstsd_pkg.sv
rtl/core/sstsd_front.sv
rtl/core/sstsd_queue.sv
rtl/core/sstsd_back.sv
rtl/core/seven_segment_text_scan_driver.sv
rtl/core/sstsd_checker.sv
bench/seven_segment_text_scan_driver_test.sv
